// ===== hw/rtl/linds_pkg.sv =====
// Shared constants for the linear interpolation downsampler.
// No dependencies; imported by linds_csr_if and by linds_front.
package linds_pkg;

   localparam int STEP_WIDTH    = 32;
   localparam int POS_INT_BITS  = 9;

endpackage

// ===== hw/rtl/linds_if.sv =====
// Stream interfaces of the downsampler: sample request, sample response, step write.
// Depends on linds_pkg for the step register width.
interface linds_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface linds_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface linds_csr_if;
   import linds_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STEP_WIDTH-1:0] step_factor;

   modport source (output valid, output step_factor, input ready);
   modport sink   (input valid, input step_factor, output ready);
endinterface

// ===== hw/rtl/linear_interp_downsampler_core.sv =====
// Linear interpolation sample rate down-converter, top level.
// Depends on linds_pkg, linds_if, linds_front, linds_queue and linds_back.
//
// Usage:
//   req_chan carries one signed high-rate sample per word. Words that land
//   before the read position crosses 1.0 yield one interpolated low-rate
//   word on rsp_chan; the others update state only and yield nothing.
//   csr_chan writes step_factor (unsigned, FRAC_BITS fraction bits, high
//   over low rate); values below 1.0 act as 1.0. Write it while idle.
//   Throughput: one request word per cycle unless the queue is full. The front end updates
//   position and previous sample in a single add per word.
//   Path of a response from its request: queue write, multiply stage, round
//   and add into the output register.
//   When rsp_chan stalls, the output register and the multiply stage hold,
//   the job queue (QUEUE_DEPTH words) fills, and req_chan.ready drops only
//   for words that would produce output while the queue is full.
//   Reset (synchronous): step_factor = 1.0, read position and previous
//   sample cleared, queue and pipeline emptied. csr_chan.ready is always high.
module linear_interp_downsampler_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 24,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic         clock,
   input  logic         reset,
   linds_req_if.sink    req_chan,
   linds_rsp_if.source  rsp_chan,
   linds_csr_if.sink    csr_chan
);
   localparam int ENTRY_W = 2 * SAMPLE_WIDTH + FRAC_BITS;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   linds_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   linds_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   linds_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== hw/rtl/linds_front.sv =====
// Front end: holds step register, read position and previous sample, accepts
// request words and pushes the ones that produce output into the queue. Uses linds_pkg.
module linds_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   linds_req_if.sink                         req_chan,
   linds_csr_if.sink                         csr_chan,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [2*SAMPLE_WIDTH+FRAC_BITS-1:0] push_data
);
   import linds_pkg::*;

   localparam int PW    = FRAC_BITS + POS_INT_BITS;
   localparam int SUM_W = (PW > STEP_WIDTH) ? PW : STEP_WIDTH;
   localparam logic [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;
   localparam logic [PW-1:0]    ONE_P = PW'(1) << FRAC_BITS;

   logic [STEP_WIDTH-1:0]          step_ff, step_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                           emit;
   logic                           accept;
   logic [SUM_W-1:0]               step_ext, step_sat, adv_sum;
   logic [PW-1:0]                  pos_adv;

   assign emit           = (pos_ff[PW-1:FRAC_BITS] == '0);
   assign req_chan.ready = !emit || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign push_valid = req_chan.valid && emit;
   assign push_data  = {prev_ff, req_chan.sample_in, pos_ff[FRAC_BITS-1:0]};

   assign step_ext = SUM_W'(step_ff);
   assign step_sat = (step_ext < ONE_S) ? ONE_S : step_ext;
   assign adv_sum  = SUM_W'(pos_ff) + step_sat;

   always_comb begin
      step_in = step_ff;
      pos_in  = pos_ff;
      prev_in = prev_ff;
      if (csr_chan.valid) begin
         step_in = csr_chan.step_factor;
      end
      pos_adv = emit ? adv_sum[PW-1:0] : pos_ff;
      if (accept) begin
         pos_in  = (pos_adv >= ONE_P) ? (pos_adv - ONE_P) : '0;
         prev_in = req_chan.sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WIDTH'(ONE_S);
         pos_ff  <= '0;
         prev_ff <= '0;
      end else begin
         step_ff <= step_in;
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
      end
   end

endmodule

// ===== hw/rtl/linds_queue.sv =====
// Short FIFO of interpolation jobs between front and back end.
// Register storage with one read pointer; no package dependencies.
module linds_queue #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/linds_back.sv =====
// Back end: two-stage interpolation pipeline, multiply then round and add,
// driving the response word register. Uses linds_rsp_if; no package items needed.
module linds_back #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [2*SAMPLE_WIDTH+FRAC_BITS-1:0] pop_data,
   linds_rsp_if.source                         rsp_chan
);
   localparam int SW    = SAMPLE_WIDTH;
   localparam int PRODW = SW + FRAC_BITS + 2;
   localparam logic signed [PRODW-1:0] HALF =
      {{(PRODW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   logic signed [SW-1:0]    a, b;
   logic [FRAC_BITS-1:0]    f;
   logic signed [SW:0]      diff;
   logic signed [PRODW-1:0] prod;
   logic signed [PRODW-1:0] prod_ff, prod_in;
   logic signed [SW-1:0]    a_ff, a_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [PRODW-1:0] rounded;
   logic signed [SW+1:0]    shifted, total;
   logic signed [SW-1:0]    out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    adv1, adv2;

   assign a    = pop_data[2*SW+FRAC_BITS-1 -: SW];
   assign b    = pop_data[SW+FRAC_BITS-1 -: SW];
   assign f    = pop_data[FRAC_BITS-1:0];
   assign diff = $signed({b[SW-1], b}) - $signed({a[SW-1], a});
   assign prod = diff * $signed({1'b0, f});

   assign adv2      = !out_valid_ff || rsp_chan.ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign pop_ready = adv1;

   assign rounded = prod_ff + HALF;
   assign shifted = rounded[PRODW-1:FRAC_BITS];
   assign total   = $signed({{2{a_ff[SW-1]}}, a_ff}) + shifted;

   always_comb begin
      prod_in      = prod_ff;
      a_in         = a_ff;
      s1_valid_in  = s1_valid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (adv1) begin
         prod_in     = prod;
         a_in        = a;
         s1_valid_in = pop_valid;
      end
      if (adv2) begin
         out_in       = total[SW-1:0];
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample_out = out_ff;

endmodule

// ===== hw/rtl/linds_checker.sv =====
// Port-level checks for linear_interp_downsampler_core, attached by bind.
// Sees only the top level's clock, reset and channel signals.
module linds_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                    csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> csr_ready)
      else $error("step write not taken");

endmodule

bind linear_interp_downsampler_core linds_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_linds_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_sample_out (rsp_chan.sample_out),
   .csr_ready      (csr_chan.ready)
);
